// ===== src/ctpu_pkg.sv =====
package ctpu_pkg;

    // command codes
    localparam logic [2:0] CMD_CSR_READ  = 3'd0;
    localparam logic [2:0] CMD_CSR_WRITE = 3'd1;
    localparam logic [2:0] CMD_TRAP      = 3'd2;
    localparam logic [2:0] CMD_MRET      = 3'd3;
    localparam logic [2:0] CMD_SRET      = 3'd4;
    localparam logic [2:0] CMD_STATUS    = 3'd5;

    // csr addresses
    localparam logic [11:0] CSR_MSTATUS = 12'h300;
    localparam logic [11:0] CSR_MIE     = 12'h304;
    localparam logic [11:0] CSR_MTVEC   = 12'h305;
    localparam logic [11:0] CSR_STVEC   = 12'h105;
    localparam logic [11:0] CSR_SEPC    = 12'h141;
    localparam logic [11:0] CSR_SCAUSE  = 12'h142;
    localparam logic [11:0] CSR_STVAL   = 12'h143;
    localparam logic [11:0] CSR_MEDELEG = 12'h302;
    localparam logic [11:0] CSR_MIDELEG = 12'h303;
    localparam logic [11:0] CSR_SATP    = 12'h180;
    localparam logic [11:0] CSR_MEPC    = 12'h341;
    localparam logic [11:0] CSR_MCAUSE  = 12'h342;

    // privilege levels
    localparam logic [1:0] PRIV_U = 2'd0;
    localparam logic [1:0] PRIV_S = 2'd1;
    localparam logic [1:0] PRIV_M = 2'd3;

    // bit positions
    localparam int MSTATUS_SIE_BIT = 1;
    localparam int MSTATUS_MIE_BIT = 3;
    localparam int MIE_UART_BIT    = 3;
    localparam int MIE_TIMER_BIT   = 7;

    localparam logic [31:0] CAUSE_MASK = 32'h7fff_ffff;

    typedef struct packed {
        logic        uart_pending_line;
        logic        timer_pending_line;
        logic        force_interrupt;
        logic [31:0] exception_pc;
        logic [31:0] trap_value;
        logic [31:0] trap_cause;
        logic [31:0] write_data;
        logic [11:0] csr_sel;
        logic [2:0]  command;
    } cmd_item_t;

    typedef struct packed {
        logic        uart_irq;
        logic        timer_irq;
        logic [1:0]  current_privilege;
        logic        illegal_access;
        logic [31:0] trap_vector;
        logic [31:0] read_data;
    } result_item_t;

endpackage

// ===== src/ctpu_core.sv =====
module ctpu_core (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ctpu_pkg::cmd_item_t   item,
    input  logic                  commit,
    output ctpu_pkg::result_item_t result
);
    import ctpu_pkg::*;

    logic [31:0] mstatus_reg, mstatus_next;
    logic [31:0] mepc_reg, mepc_next;
    logic [31:0] mcause_reg, mcause_next;
    logic [31:0] mtvec_reg, mtvec_next;
    logic [31:0] sepc_reg, sepc_next;
    logic [31:0] scause_reg, scause_next;
    logic [31:0] stval_reg, stval_next;
    logic [31:0] stvec_reg, stvec_next;
    logic [31:0] satp_reg, satp_next;
    logic [31:0] medeleg_reg, medeleg_next;
    logic [31:0] mideleg_reg, mideleg_next;
    logic [1:0]  priv_reg, priv_next;
    logic        timer_en_reg, timer_en_next;
    logic        uart_en_reg, uart_en_next;
    logic [1:0]  mpp_reg, mpp_next;
    logic        mpie_reg, mpie_next;
    logic        spie_reg, spie_next;
    logic        spp_reg, spp_next;
    logic        sie_reg, sie_next;

    logic [31:0] csr_rd;
    logic        is_intr;
    logic [31:0] cause_num;
    logic [31:0] deleg;
    logic        to_super;
    logic        mie_after;

    // csr read mux
    always_comb begin
        unique case (item.csr_sel)
            CSR_MSTATUS: begin
                csr_rd = mstatus_reg;
                csr_rd[MSTATUS_SIE_BIT] = sie_reg;
            end
            CSR_MIE: begin
                csr_rd = '0;
                csr_rd[MIE_TIMER_BIT] = timer_en_reg;
                csr_rd[MIE_UART_BIT]  = uart_en_reg;
            end
            CSR_MTVEC:   csr_rd = mtvec_reg;
            CSR_STVEC:   csr_rd = stvec_reg;
            CSR_SEPC:    csr_rd = sepc_reg;
            CSR_SCAUSE:  csr_rd = scause_reg;
            CSR_STVAL:   csr_rd = stval_reg;
            CSR_MEDELEG: csr_rd = medeleg_reg;
            CSR_MIDELEG: csr_rd = mideleg_reg;
            CSR_SATP:    csr_rd = satp_reg;
            CSR_MEPC:    csr_rd = mepc_reg;
            CSR_MCAUSE:  csr_rd = mcause_reg;
            default:     csr_rd = '0;
        endcase
    end

    // delegation decision
    assign is_intr   = item.trap_cause[31] | item.force_interrupt;
    assign cause_num = item.trap_cause & CAUSE_MASK;
    assign deleg     = is_intr ? mideleg_reg : medeleg_reg;
    assign to_super  = (cause_num[30:5] == '0) && deleg[cause_num[4:0]]
                       && (priv_reg <= PRIV_S);

    always_comb begin
        mstatus_next  = mstatus_reg;
        mepc_next     = mepc_reg;
        mcause_next   = mcause_reg;
        mtvec_next    = mtvec_reg;
        sepc_next     = sepc_reg;
        scause_next   = scause_reg;
        stval_next    = stval_reg;
        stvec_next    = stvec_reg;
        satp_next     = satp_reg;
        medeleg_next  = medeleg_reg;
        mideleg_next  = mideleg_reg;
        priv_next     = priv_reg;
        timer_en_next = timer_en_reg;
        uart_en_next  = uart_en_reg;
        mpp_next      = mpp_reg;
        mpie_next     = mpie_reg;
        spie_next     = spie_reg;
        spp_next      = spp_reg;
        sie_next      = sie_reg;

        result.read_data      = '0;
        result.trap_vector    = '0;
        result.illegal_access = 1'b0;

        unique case (item.command)
            CMD_CSR_READ: begin
                if (item.csr_sel == CSR_MSTATUS && priv_reg == PRIV_U) begin
                    result.illegal_access = 1'b1;
                end else begin
                    result.read_data = csr_rd;
                end
            end
            CMD_CSR_WRITE: begin
                unique case (item.csr_sel)
                    CSR_MSTATUS: mstatus_next = item.write_data;
                    CSR_MIE: begin
                        timer_en_next = item.write_data[MIE_TIMER_BIT];
                        uart_en_next  = item.write_data[MIE_UART_BIT];
                    end
                    CSR_MTVEC:   mtvec_next   = item.write_data;
                    CSR_STVEC:   stvec_next   = item.write_data;
                    CSR_SEPC:    sepc_next    = item.write_data;
                    CSR_SCAUSE:  scause_next  = item.write_data;
                    CSR_STVAL:   stval_next   = item.write_data;
                    CSR_MEDELEG: medeleg_next = item.write_data;
                    CSR_MIDELEG: mideleg_next = item.write_data;
                    CSR_SATP:    satp_next    = item.write_data;
                    CSR_MEPC:    mepc_next    = item.write_data;
                    CSR_MCAUSE:  mcause_next  = item.write_data;
                    default: ;
                endcase
            end
            CMD_TRAP: begin
                if (to_super) begin
                    sepc_next   = item.exception_pc;
                    scause_next = item.trap_cause;
                    stval_next  = item.trap_value;
                    spie_next   = sie_reg;
                    sie_next    = 1'b0;
                    spp_next    = (priv_reg == PRIV_S);
                    priv_next   = PRIV_S;
                    result.trap_vector = stvec_reg;
                end else begin
                    mepc_next   = item.exception_pc;
                    mcause_next = item.trap_cause;
                    mpie_next   = mstatus_reg[MSTATUS_MIE_BIT];
                    mstatus_next[MSTATUS_MIE_BIT] = 1'b0;
                    mpp_next    = priv_reg;
                    priv_next   = PRIV_M;
                    result.trap_vector = mtvec_reg;
                end
            end
            CMD_MRET: begin
                priv_next = mpp_reg;
                mstatus_next[MSTATUS_MIE_BIT] = mpie_reg;
                mpie_next = 1'b0;
                mpp_next  = PRIV_U;
            end
            CMD_SRET: begin
                priv_next = spp_reg ? PRIV_S : PRIV_U;
                sie_next  = spie_reg;
                spie_next = 1'b0;
                spp_next  = 1'b0;
            end
            default: ;
        endcase

        // irq lines follow the state after this command
        mie_after                = mstatus_next[MSTATUS_MIE_BIT];
        result.current_privilege = priv_next;
        result.timer_irq         = mie_after & timer_en_next & item.timer_pending_line;
        result.uart_irq          = mie_after & uart_en_next & item.uart_pending_line;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mstatus_reg  <= '0;
            mepc_reg     <= '0;
            mcause_reg   <= '0;
            mtvec_reg    <= '0;
            sepc_reg     <= '0;
            scause_reg   <= '0;
            stval_reg    <= '0;
            stvec_reg    <= '0;
            satp_reg     <= '0;
            medeleg_reg  <= '0;
            mideleg_reg  <= '0;
            priv_reg     <= PRIV_M;
            timer_en_reg <= 1'b0;
            uart_en_reg  <= 1'b0;
            mpp_reg      <= PRIV_M;
            mpie_reg     <= 1'b0;
            spie_reg     <= 1'b0;
            spp_reg      <= 1'b0;
            sie_reg      <= 1'b0;
        end else if (commit) begin
            mstatus_reg  <= mstatus_next;
            mepc_reg     <= mepc_next;
            mcause_reg   <= mcause_next;
            mtvec_reg    <= mtvec_next;
            sepc_reg     <= sepc_next;
            scause_reg   <= scause_next;
            stval_reg    <= stval_next;
            stvec_reg    <= stvec_next;
            satp_reg     <= satp_next;
            medeleg_reg  <= medeleg_next;
            mideleg_reg  <= mideleg_next;
            priv_reg     <= priv_next;
            timer_en_reg <= timer_en_next;
            uart_en_reg  <= uart_en_next;
            mpp_reg      <= mpp_next;
            mpie_reg     <= mpie_next;
            spie_reg     <= spie_next;
            spp_reg      <= spp_next;
            sie_reg      <= sie_next;
        end
    end

endmodule

// ===== src/csr_trap_privilege_unit_top.sv =====
// Simplified RV32 CSR and trap unit. Each input transaction carries one
// command (csr read, csr write, trap entry, mret, sret or status only) and
// produces exactly one result transaction with the read value, the trap
// vector, an illegal-access flag for user reads of mstatus, the privilege
// after the command and the gated timer and uart interrupt requests. The
// command is registered on input, decoded against the CSR state by one level
// of combinational logic and the result is registered on output, so the
// unit accepts one transaction per cycle unless m_tready stalls the output.
// The CSR state updates as a command leaves the input register, so
// back-to-back commands see each other's effects in order.
module csr_trap_privilege_unit_top (
    input  logic         aclk,
    input  logic         aresetn,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    // csr_sel[11:0], write_data[43:12], trap_cause[75:44], trap_value[107:76],
    // exception_pc[139:108], force_interrupt[140], timer_pending_line[141],
    // uart_pending_line[142], zero pad[143]
    input  logic [143:0] s_tdata,
    // command[2:0]
    input  logic [2:0]   s_tuser,
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    // read_data[31:0], trap_vector[63:32], illegal_access[64],
    // current_privilege[66:65], timer_irq[67], uart_irq[68], zero pad[71:69]
    output logic [71:0]  m_tdata
);
    import ctpu_pkg::*;

    // input register
    logic         in_valid_reg;
    cmd_item_t    in_item_reg;

    // result register
    logic         out_valid_reg;
    result_item_t out_item_reg;

    result_item_t core_result;
    logic         out_free;
    logic         advance;

    // the result register can take a new item when empty or being drained
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    // unpack the input transaction
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg.command            <= s_tuser;
            in_item_reg.csr_sel            <= s_tdata[11:0];
            in_item_reg.write_data         <= s_tdata[43:12];
            in_item_reg.trap_cause         <= s_tdata[75:44];
            in_item_reg.trap_value         <= s_tdata[107:76];
            in_item_reg.exception_pc       <= s_tdata[139:108];
            in_item_reg.force_interrupt    <= s_tdata[140];
            in_item_reg.timer_pending_line <= s_tdata[141];
            in_item_reg.uart_pending_line  <= s_tdata[142];
        end
    end

    // csr state and command decode; state commits when the item moves on
    ctpu_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .item    (in_item_reg),
        .commit  (advance),
        .result  (core_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_item_reg <= core_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_item_reg};

endmodule
